### hw/rtl/qat_pkg.sv
`timescale 1ns / 1ps
package qat_pkg;

	localparam int unsigned MAX_WORDS_LIMIT_DEF = 255;
	localparam logic [7:0] MAX_TOKENS_RST = 8'd63;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOW  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// line status codes
	localparam logic [1:0] ST_PLAIN    = 2'd0;
	localparam logic [1:0] ST_OPEN_Q   = 2'd1;
	localparam logic [1:0] ST_ESCAPE   = 2'd2;
	localparam logic [1:0] ST_TRAIL    = 2'd3;

	// quote modes
	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_SINGLE = 2'd1;
	localparam logic [1:0] QM_DOUBLE = 2'd2;

	// special bytes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	localparam logic [2:0] ADDR_MAX_TOKENS = 3'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] word_index;
		logic [1:0] line_status;
		logic       last;
	} res_t;

	// up to two results per input byte
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### hw/rtl/qat_core.sv
`timescale 1ns / 1ps
module qat_core #(
	parameter int unsigned MAX_WORDS_LIMIT = qat_pkg::MAX_WORDS_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [7:0]    char_in,
	input  logic [7:0]    max_tokens,
	output qat_pkg::push_t push
);
	import qat_pkg::*;

	localparam logic [7:0] LimCap = (MAX_WORDS_LIMIT > 255) ? 8'd255 : 8'(MAX_WORDS_LIMIT);

	logic [1:0] qm_q, qm_d;
	logic       esc_q, esc_d;
	logic       esl_q, esl_d;
	logic       skip_q, skip_d;
	logic [7:0] wc_q, wc_d;
	logic       has_q, has_d;
	logic       trail_q, trail_d;
	logic       limr_q, limr_d;

	logic [7:0] lim;
	logic [7:0] wc_inc;
	logic       close;
	logic [1:0] status;
	logic [1:0] qcode;
	res_t       eol, eow, byt;

	assign lim    = (max_tokens < LimCap) ? max_tokens : LimCap;
	assign wc_inc = wc_q + 8'd1;
	assign qcode  = (char_in == CH_SQ) ? QM_SINGLE : QM_DOUBLE;

	always_comb begin
		close = !limr_q && (wc_q < lim) && (has_q || qm_q != QM_NONE);
		if (qm_q != QM_NONE) status = ST_OPEN_Q;
		else if (esc_q || esl_q) status = ST_ESCAPE;
		else if (trail_q) status = ST_TRAIL;
		else status = ST_PLAIN;
		eol = '{kind: KIND_EOL, data_byte: 8'd0, word_index: close ? wc_inc : wc_q,
			line_status: status, last: 1'b1};
		eow = '{kind: KIND_EOW, data_byte: 8'd0, word_index: wc_q,
			line_status: ST_PLAIN, last: 1'b0};
		byt = '{kind: KIND_BYTE, data_byte: char_in, word_index: wc_q,
			line_status: ST_PLAIN, last: 1'b0};
	end

	always_comb begin
		qm_d    = qm_q;
		esc_d   = esc_q;
		esl_d   = esl_q;
		skip_d  = skip_q;
		wc_d    = wc_q;
		has_d   = has_q;
		trail_d = trail_q;
		limr_d  = limr_q;
		push    = '{n: 2'd0, r0: byt, r1: eol};
		if (!valid) begin
			push.n = 2'd0;
		end else if (char_in == CH_NUL) begin
			// close pending word, report, and rearm for the next line
			push.n  = close ? 2'd2 : 2'd1;
			push.r0 = close ? eow : eol;
			qm_d    = QM_NONE;
			esc_d   = 1'b0;
			esl_d   = 1'b0;
			skip_d  = 1'b1;
			wc_d    = 8'd0;
			has_d   = 1'b0;
			trail_d = 1'b0;
			limr_d  = 1'b0;
		end else if (limr_q || wc_q >= lim) begin
			push.n = 2'd0;
		end else if (esc_q) begin
			esc_d  = 1'b0;
			esl_d  = (char_in == CH_SPACE);
			has_d  = 1'b1;
			push.n = 2'd1;
		end else begin
			esl_d = 1'b0;
			if (!(skip_q && char_in == CH_SPACE)) begin
				skip_d  = 1'b0;
				trail_d = 1'b0;
				if (char_in == CH_BSL) begin
					esc_d = 1'b1;
				end else if ((char_in == CH_DQ || char_in == CH_SQ) &&
					(qm_q == QM_NONE || qm_q == qcode)) begin
					qm_d = (qm_q == QM_NONE) ? qcode : QM_NONE;
				end else if (char_in == CH_SPACE && qm_q == QM_NONE) begin
					push.n  = 2'd1;
					push.r0 = eow;
					wc_d    = wc_inc;
					trail_d = 1'b1;
					skip_d  = 1'b1;
					has_d   = 1'b0;
					limr_d  = (wc_inc >= lim);
				end else begin
					has_d  = 1'b1;
					push.n = 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q    <= QM_NONE;
			esc_q   <= 1'b0;
			esl_q   <= 1'b0;
			skip_q  <= 1'b1;
			wc_q    <= 8'd0;
			has_q   <= 1'b0;
			trail_q <= 1'b0;
			limr_q  <= 1'b0;
		end else begin
			qm_q    <= qm_d;
			esc_q   <= esc_d;
			esl_q   <= esl_d;
			skip_q  <= skip_d;
			wc_q    <= wc_d;
			has_q   <= has_d;
			trail_q <= trail_d;
			limr_q  <= limr_d;
		end
	end

endmodule

### hw/rtl/qat_fifo.sv
`timescale 1ns / 1ps
module qat_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  qat_pkg::push_t push,
	output logic           room2,
	output logic           out_valid,
	input  logic           out_ready,
	output qat_pkg::res_t  out_res
);
	import qat_pkg::*;

	localparam int Depth = 4;
	localparam int Aw = $clog2(Depth);

	res_t          mem [Depth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0]   cnt_q;
	logic          pop;
	logic [Aw:0]   n_ext;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem[rd_q];
	assign room2     = (cnt_q <= (Aw+1)'(Depth - 2));
	assign n_ext     = (Aw+1)'(push.n);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem[wr_q] <= push.r0;
		if (push.n == 2'd2) mem[wr_q + Aw'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Aw'(push.n);
			if (pop) rd_q <= rd_q + Aw'(1);
			cnt_q <= cnt_q + n_ext - (Aw+1)'(pop);
		end
	end

endmodule

### hw/rtl/quoted_argument_tokenizer.sv
`timescale 1ns / 1ps
// Quoted argument tokenizer: splits a byte stream into shell-style words.
//
// Input stream (s_*): one byte of a line per word; a zero byte ends the line.
// Output stream (m_*): kept bytes tagged with their word index, an end-of-word
// marker per word, and one end-of-line word carrying the word count and a
// status (plain, open quote, dangling escape, trailing delimiter); m_tlast
// marks that end-of-line word.
// APB port: register 0 (address 0x0) is max_tokens, words accepted per line.
//
// Path: an accepted byte sits in the input register, then is processed by
// the core and queued in the output queue, which drives m_*.
// Throughput: one byte per cycle while the queue has room; each byte gives at
// most one result except the line terminator, which may give two (end of
// word and end of line). A four-entry output queue takes them; the input
// register advances only when the queue holds two or fewer, so a stalled
// receiver backs up into s_tready and nothing is lost. Even with m_tready held
// high, two-result terminators can fill the queue to three and stall the input.
// Reset: max_tokens returns to 63, the line state to line start, and the
// queue empties.
module quoted_argument_tokenizer #(
	parameter int unsigned MAX_WORDS_LIMIT = qat_pkg::MAX_WORDS_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] data_byte, [15:8] word_index, [17:16] line_status
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	// APB config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import qat_pkg::*;

	logic [7:0] max_tokens_q;
	logic       v_s1;
	logic [7:0] char_s1;
	logic       fire;
	logic       room2;
	push_t      push;
	res_t       res;

	// config register; pready tied high, so writes land in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_TOKENS) ? {24'd0, max_tokens_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_TOKENS) begin
			max_tokens_q <= pwdata[7:0];
		end
	end

	// input register: drains into the core whenever the queue can take two
	assign fire     = v_s1 && room2;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) char_s1 <= s_tdata;
	end

	qat_core #(
		.MAX_WORDS_LIMIT(MAX_WORDS_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (fire),
		.char_in   (char_s1),
		.max_tokens(max_tokens_q),
		.push      (push)
	);

	qat_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room2    (room2),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {6'd0, res.line_status, res.word_index, res.data_byte};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

### bench/quoted_argument_tokenizer_tb.sv
`timescale 1ns / 1ps
module quoted_argument_tokenizer_tb;
	import qat_pkg::*;

	// ------------------------------------------------------------------
	// clock, reset, DUT ports
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_in
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [7:0] data_byte, [15:8] word_index, [17:16] line_status
	logic [1:0]  m_tuser;   // [1:0] kind
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	always #5 clk = ~clk;

	quoted_argument_tokenizer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ------------------------------------------------------------------
	// splitter state as the bench tracks it
	// ------------------------------------------------------------------
	logic [7:0] tok_limit;     // max_tokens; never above MAX_WORDS_LIMIT (255)
	logic [1:0] qmode;         // QM_NONE / QM_SINGLE / QM_DOUBLE
	bit         esc_pending;   // last byte was an unquoted/quoted backslash
	bit         esc_space;     // last kept byte was an escaped space
	bit         skip_lead;     // swallowing spaces (line start or after a word)
	int         n_words;       // words closed so far on this line
	bit         word_kept;     // current word has kept a byte
	bit         trail_delim;   // last thing seen was a delimiter
	bit         at_limit;      // word limit hit, rest of line is dropped

	res_t       token_events_q[$];   // words the splitter still owes us
	int         fault_count = 0;

	bit         sender_gaps = 1'b0;  // random holes in s_tvalid
	bit         sink_stalls = 1'b0;  // random holes in m_tready

	logic [7:0] line_bytes[$];       // line under construction (no terminator)

	function automatic void line_restart();
		qmode       = QM_NONE;
		esc_pending = 1'b0;
		esc_space   = 1'b0;
		skip_lead   = 1'b1;
		n_words     = 0;
		word_kept   = 1'b0;
		trail_delim = 1'b0;
		at_limit    = 1'b0;
	endfunction

	function automatic void owe_word(input logic [1:0] kind, input logic [7:0] data,
			input int idx, input logic [1:0] status, input logic fin);
		res_t r;
		r.kind        = kind;
		r.data_byte   = data;
		r.word_index  = idx[7:0];
		r.line_status = status;
		r.last        = fin;
		token_events_q.push_back(r);
	endfunction

	// One accepted input byte -> zero, one or two owed output words.
	function automatic void tokenize_byte(input logic [7:0] c);
		logic [1:0] st;
		logic [1:0] qc;
		if (c == CH_NUL) begin
			// close pending word only if under the limit and something to close
			if (!at_limit && n_words < int'(tok_limit) && (word_kept || qmode != QM_NONE)) begin
				owe_word(KIND_EOW, 8'h00, n_words, ST_PLAIN, 1'b0);
				n_words++;
			end
			// open quote wins over escape, escape over trailing delimiter
			if (qmode != QM_NONE)
				st = ST_OPEN_Q;
			else if (esc_pending || esc_space)
				st = ST_ESCAPE;
			else if (trail_delim)
				st = ST_TRAIL;
			else
				st = ST_PLAIN;
			owe_word(KIND_EOL, 8'h00, n_words, st, 1'b1);
			line_restart();
			return;
		end

		// past the limit: dropped, no state change
		if (at_limit || n_words >= int'(tok_limit))
			return;

		if (esc_pending) begin
			esc_pending = 1'b0;
			esc_space   = (c == CH_SPACE);
			word_kept   = 1'b1;
			owe_word(KIND_BYTE, c, n_words, ST_PLAIN, 1'b0);
			return;
		end
		esc_space = 1'b0;

		if (skip_lead && c == CH_SPACE)
			return;
		skip_lead   = 1'b0;
		trail_delim = 1'b0;

		if (c == CH_BSL) begin
			esc_pending = 1'b1;
			return;
		end

		if (c == CH_DQ || c == CH_SQ) begin
			qc = (c == CH_SQ) ? QM_SINGLE : QM_DOUBLE;
			if (qmode == QM_NONE) begin
				qmode = qc;
				return;
			end
			if (qmode == qc) begin
				qmode = QM_NONE;
				return;
			end
			// other quote kind inside a span falls through as a kept byte
		end else if (c == CH_SPACE && qmode == QM_NONE) begin
			owe_word(KIND_EOW, 8'h00, n_words, ST_PLAIN, 1'b0);
			n_words++;
			trail_delim = 1'b1;
			skip_lead   = 1'b1;
			word_kept   = 1'b0;
			if (n_words >= int'(tok_limit))
				at_limit = 1'b1;
			return;
		end

		word_kept = 1'b1;
		owe_word(KIND_BYTE, c, n_words, ST_PLAIN, 1'b0);
	endfunction

	// ------------------------------------------------------------------
	// output side: stall pattern and word checker
	// ------------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			fault_count++;
		end
	endfunction

	// pre-edge values are read here, DUT updates land in the NBA region
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_events_q.size() == 0) begin
				$display("%0t ns: unexpected word: expected none, actual kind %0d tdata %h last %0d",
					$time, m_tuser, m_tdata, m_tlast);
				fault_count++;
			end else begin
				want = token_events_q.pop_front();
				check_field("kind",        int'(want.kind),        int'(m_tuser));
				check_field("data_byte",   int'(want.data_byte),   int'(m_tdata[7:0]));
				check_field("word_index",  int'(want.word_index),  int'(m_tdata[15:8]));
				check_field("line_status", int'(want.line_status), int'(m_tdata[17:16]));
				check_field("tdata pad",   0,                      int'(m_tdata[23:18]));
				check_field("tlast",       int'(want.last),        int'(m_tlast));
			end
		end
	end

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------
	// Drive one byte; tvalid stays high into the next call unless a gap is
	// drawn, so back-to-back words never see a drop.
	task automatic send_char(input logic [7:0] c);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = c;
		do @(posedge clk); while (!s_tready);
		tokenize_byte(c);
	endtask

	// must follow the last send_char directly, before the next edge
	task automatic sender_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_line(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(CH_NUL);
	endtask

	// all owed words out, plus an extra wait for a byte still in the input reg
	task automatic wait_quiet();
		while (token_events_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB
	// ------------------------------------------------------------------
	task automatic apb_access(input logic wr, input logic [7:0] val, output logic [31:0] rd);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = ADDR_MAX_TOKENS;
		pwdata  = {24'h0, val};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (wr)
			tok_limit = val;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic read_check();
		logic [31:0] rd;
		apb_access(1'b0, 8'h00, rd);
		if (rd !== {24'h0, tok_limit}) begin
			$display("%0t ns: max_tokens readback mismatch: expected %0d, actual %0d",
				$time, tok_limit, rd);
			fault_count++;
		end
	endtask

	task automatic set_max_tokens(input logic [7:0] v);
		logic [31:0] rd;
		sender_idle();
		wait_quiet();
		apb_access(1'b1, v, rd);
		read_check();
	endtask

	// ------------------------------------------------------------------
	// random line builder
	// ------------------------------------------------------------------
	function automatic logic [7:0] plain_char();
		string pool;
		pool = "abcdefghijklmnopqrstuvwxyzABCXYZ0189-_./=~";
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// bias toward the bytes the splitter cares about
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_SQ;
			2: return CH_DQ;
			3: return CH_BSL;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic add_piece();
		logic [7:0] q;
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				repeat ($urandom_range(1, 4)) line_bytes.push_back(plain_char());
			end
			3: begin
				// quoted span: spaces, the other quote kind and escapes inside
				q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
				line_bytes.push_back(q);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 3))
						0: line_bytes.push_back(plain_char());
						1: line_bytes.push_back(CH_SPACE);
						2: line_bytes.push_back(q == CH_SQ ? CH_DQ : CH_SQ);
						default: begin
							line_bytes.push_back(CH_BSL);
							line_bytes.push_back(8'($urandom_range(1, 255)));
						end
					endcase
				end
				line_bytes.push_back(q);
			end
			4: begin
				line_bytes.push_back(CH_BSL);
				line_bytes.push_back(8'($urandom_range(1, 255)));
			end
			default: begin
				// empty quote pair or an escaped space
				if ($urandom_range(0, 1)) begin
					q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
					line_bytes.push_back(q);
					line_bytes.push_back(q);
				end else begin
					line_bytes.push_back(CH_BSL);
					line_bytes.push_back(CH_SPACE);
				end
			end
		endcase
	endtask

	// mostly well-formed lines; some are raw noise, some end broken
	task automatic build_random_line();
		int shape;
		int nwords;
		int w;
		line_bytes.delete();
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			repeat ($urandom_range(0, 16)) line_bytes.push_back(noise_byte());
			return;
		end
		repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SPACE);
		nwords = $urandom_range(1, 6);
		for (w = 0; w < nwords; w++) begin
			repeat ($urandom_range(1, 3)) add_piece();
			if (w != nwords - 1)
				repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_SPACE);
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
		if (shape == 1) begin
			case ($urandom_range(0, 2))
				0: line_bytes.push_back(CH_SQ);
				1: line_bytes.push_back(CH_DQ);
				default: line_bytes.push_back(CH_BSL);
			endcase
			if ($urandom_range(0, 1))
				line_bytes.push_back(plain_char());
		end
	endtask

	task automatic send_random_lines(input int budget, input bit calm);
		int sent;
		int i;
		sent = 0;
		while (sent < budget) begin
			build_random_line();
			sender_gaps = !calm && $urandom_range(0, 3) != 0;
			sink_stalls = !calm && $urandom_range(0, 3) != 0;
			for (i = 0; i < line_bytes.size(); i++)
				send_char(line_bytes[i]);
			send_char(CH_NUL);
			sent += line_bytes.size() + 1;
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_reset_value();
		read_check();
	endtask

	// leading spaces, collapsed runs, trailing delimiter; both quote kinds
	// nested literally; empty word; escaped final space; dangling backslash;
	// open quote; top and bottom byte values; empty line
	task automatic test_quoting_rules();
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		send_line(" a  b ");
		send_line("'\"'\"'\"");
		send_line("\"\" x");
		send_line("\\ ");
		send_line("\\");
		send_line("'");
		send_char(8'hFF);
		send_char(8'h01);
		send_char(CH_NUL);
		send_line("");
	endtask

	// limit 0 drops every byte, limit 1 keeps one word, limit 2 keeps two
	task automatic test_small_limits();
		set_max_tokens(8'd0);
		send_line(" a b");
		set_max_tokens(8'd1);
		send_line("a b");
		set_max_tokens(8'd2);
		send_line("a b c");
	endtask

	// lower the limit below the count already reached in the middle of a line
	task automatic test_mid_line_write();
		set_max_tokens(MAX_TOKENS_RST);
		send_char("a");
		send_char(CH_SPACE);
		send_char("b");
		send_char(CH_SPACE);
		send_char("c");
		send_char(CH_SPACE);
		set_max_tokens(8'd2);
		send_char("d");
		send_char(CH_NUL);
	endtask

	// more one-byte words than the limit: count stops at the limit, rest dropped
	task automatic test_full_vector();
		set_max_tokens(8'd48);
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
		repeat (52) begin
			send_char(plain_char());
			send_char(CH_SPACE);
		end
		send_char(CH_NUL);
	endtask

	task automatic test_random_lines();
		set_max_tokens(MAX_TOKENS_RST);
		send_random_lines(60, 1'b0);
		set_max_tokens(8'd2);
		send_random_lines(50, 1'b0);
		set_max_tokens(8'd255);
		send_random_lines(50, 1'b0);
		set_max_tokens(8'd3);
		send_random_lines(50, 1'b0);
		set_max_tokens(8'($urandom_range(2, 255)));
		send_random_lines(60, 1'b0);
	endtask

	// closing stretch at full rate on both sides
	task automatic test_unstalled_tail();
		set_max_tokens(8'($urandom_range(2, 6)));
		send_random_lines(50, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		tok_limit = MAX_TOKENS_RST;
		line_restart();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_value();
		test_quoting_rules();
		test_small_limits();
		test_mid_line_write();
		test_full_vector();
		test_random_lines();
		test_unstalled_tail();

		sender_idle();
		while (token_events_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("** quoted_argument_tokenizer: PASSED **");
		else
			$display("** quoted_argument_tokenizer: FAILED **");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d words still owed", token_events_q.size());
		$display("** quoted_argument_tokenizer: FAILED **");
		$finish;
	end

endmodule
